[src/sem_pkg.sv]
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int ROW_W  = 2 * PIX_W;
    localparam int SQ_W   = 21;
    localparam int ADDR_W = 3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(MAX_HEIGHT);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [SQ_W-1:0] ROOT_SAT = SQ_W'(65280);
    localparam logic [CH_W-1:0] CH_MAX   = CH_W'(255);

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_sts;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

[src/sem_ram.sv]
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sem_root.sv]
`timescale 1ns / 1ps

module sem_root (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sem_pkg::SQ_W-1:0]  i_val,
    output logic [sem_pkg::CH_W-1:0]  o_root,
    output sem_pkg::t_root_sts        o_sts
);

    logic [sem_pkg::SQ_W-1:0] r_v;
    logic [sem_pkg::CH_W-1:0] r_k;
    logic [2:0]               r_step;
    logic                     r_busy;
    logic                     r_done;
    logic [sem_pkg::CH_W-1:0] t_try;
    logic [2*sem_pkg::CH_W-1:0] t_sq;
    logic [2*sem_pkg::CH_W:0]   k_lim;

    // one result bit per cycle, most significant first
    assign t_try = r_k | (sem_pkg::CH_W'(1) << r_step);
    assign t_sq  = t_try * t_try;
    assign k_lim = (2*sem_pkg::CH_W+1)'(r_k) * (2*sem_pkg::CH_W+1)'(r_k)
                 + (2*sem_pkg::CH_W+1)'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_step == 3'd0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_k    <= '0;
            r_step <= 3'd7;
        end else if (r_busy) begin
            if (sem_pkg::SQ_W'(t_sq) <= r_v) begin
                r_k <= t_try;
            end
            r_step <= r_step - 3'd1;
        end
    end

    always_comb begin
        if (r_v > sem_pkg::ROOT_SAT) begin
            o_root = sem_pkg::CH_MAX;
        end else if (r_v > sem_pkg::SQ_W'(k_lim)) begin
            o_root = r_k + sem_pkg::CH_W'(1);
        end else begin
            o_root = r_k;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

[src/sobel_edge_magnitude_rgb.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// in       | input     | i_in_valid / o_in_stall    | i_in_red, i_in_green, i_in_blue, i_flush
// out      | output    | o_out_valid / i_out_stall  | o_out_red, o_out_green, o_out_blue,
//          |           |                            | o_frame_end
// cfg      | input     | APB psel/penable/pwrite    | frame_width @0x0, frame_height @0x4
//
// A beat that produces no result goes through accept and the row store
// read-modify-write; one that does also goes through gradient, eight steps of
// the bit-serial root, a state that sees the root finish, then a hand-off to
// the output register, which waits while a held result is stalled.
// A flush beat inside the frame is dropped in its accept cycle.
// Reset is synchronous, active low, clears control and the window; the row
// store is never cleared. The output register lets the next beat enter while a
// result waits under i_out_stall.

module sobel_edge_magnitude_rgb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sem_pkg::CH_W-1:0]     i_in_red,
    input  logic [sem_pkg::CH_W-1:0]     i_in_green,
    input  logic [sem_pkg::CH_W-1:0]     i_in_blue,
    input  logic                         i_flush,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sem_pkg::CH_W-1:0]     o_out_red,
    output logic [sem_pkg::CH_W-1:0]     o_out_green,
    output logic [sem_pkg::CH_W-1:0]     o_out_blue,
    output logic                         o_frame_end,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sem_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    localparam int PW = sem_pkg::PIX_W;
    localparam int QW = sem_pkg::POS_W + 1;

    // configuration
    logic [sem_pkg::DIM_W-1:0] r_width;
    logic [sem_pkg::DIM_W-1:0] r_height;
    logic [sem_pkg::DIM_W-1:0] w_eff;
    logic [sem_pkg::DIM_W-1:0] h_eff;
    logic [QW-1:0]             total;
    logic                      cfg_wr;

    // control
    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [sem_pkg::POS_W-1:0] r_pos;
    logic [sem_pkg::COL_W-1:0] r_col;
    logic [sem_pkg::COL_W-1:0] r_ocol;
    logic [PW-1:0]             r_x;
    logic                      in_acc;
    logic                      in_drop;

    // window, top row first, left column first
    logic [PW-1:0]             r_win [3][3];
    logic [PW-1:0]             m_win [3][3];
    logic                      r_off_top;
    logic                      r_off_bot;
    logic                      r_off_lft;
    logic                      r_off_rgt;
    logic                      r_end;

    // row store
    logic [sem_pkg::ROW_W-1:0] ram_rdata;
    logic [PW-1:0]             row_top;
    logic [PW-1:0]             row_mid;
    logic                      rmw_we;

    logic [QW-1:0]             q;
    logic                      has_out;

    // roots
    logic [sem_pkg::SQ_W-1:0]  sq_v [3];
    logic [sem_pkg::CH_W-1:0]  root [3];
    sem_pkg::t_root_sts        root_sts [3];
    logic                      root_go;

    // output register
    logic                      r_out_valid;
    logic [sem_pkg::CH_W-1:0]  r_out_ch [3];
    logic                      r_out_end;
    logic                      out_load;

    assign w_eff  = sem_pkg::eff_dim(r_width,  sem_pkg::WIDTH_RST);
    assign h_eff  = sem_pkg::eff_dim(r_height, sem_pkg::HEIGHT_RST);
    assign total  = QW'(w_eff) * QW'(h_eff);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sem_pkg::REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // a flush inside the frame changes nothing
    assign in_drop    = (QW'(r_pos) < total) && i_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_RST;
            r_height <= sem_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == sem_pkg::REG_WIDTH) begin
                r_width <= pwdata[sem_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[sem_pkg::DIM_W-1:0];
            end
        end
    end

    // hold the pixel of the accepted beat; past the frame it counts as zero
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= (QW'(r_pos) < total) ? {i_in_red, i_in_green, i_in_blue} : '0;
        end
    end

    sem_ram #(
        .WIDTH (sem_pkg::ROW_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (rmw_we),
        .i_waddr (r_col),
        .i_wdata ({row_mid, r_x}),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign row_top = ram_rdata[sem_pkg::ROW_W-1:PW];
    assign row_mid = ram_rdata[PW-1:0];
    assign rmw_we  = (r_state == S_RMW);

    // output position of this beat; results lag by width+1
    assign q       = QW'(r_pos) - QW'(w_eff) - QW'(1);
    assign has_out = QW'(r_pos) >= QW'(w_eff) + QW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_col  <= '0;
            r_ocol <= '0;
        end else if (cfg_wr) begin
            // restart the frame
            r_pos  <= '0;
            r_col  <= '0;
            r_ocol <= '0;
        end else if (r_state == S_RMW) begin
            if (has_out && (q + QW'(1) >= total)) begin
                r_pos  <= '0;
                r_col  <= '0;
                r_ocol <= '0;
            end else begin
                r_pos <= r_pos + sem_pkg::POS_W'(1);
                if (sem_pkg::DIM_W'(r_col) + sem_pkg::DIM_W'(1) == w_eff) begin
                    r_col <= '0;
                end else begin
                    r_col <= r_col + sem_pkg::COL_W'(1);
                end
                if (has_out) begin
                    if (sem_pkg::DIM_W'(r_ocol) + sem_pkg::DIM_W'(1) == w_eff) begin
                        r_ocol <= '0;
                    end else begin
                        r_ocol <= r_ocol + sem_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

    // advance the window and latch the edge masks for this result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_state == S_RMW) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= row_top;
            r_win[1][2] <= row_mid;
            r_win[2][2] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            r_off_top <= q < QW'(w_eff);
            r_off_bot <= q + QW'(w_eff) >= total;
            r_off_lft <= r_ocol == '0;
            r_off_rgt <= sem_pkg::DIM_W'(r_ocol) + sem_pkg::DIM_W'(1) >= w_eff;
            r_end     <= q + QW'(1) >= total;
        end
    end

    // zero the taps that fall outside the frame
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && r_off_top) || (r == 2 && r_off_bot) ||
                    (c == 0 && r_off_lft) || (c == 2 && r_off_rgt)) begin
                    m_win[r][c] = '0;
                end else begin
                    m_win[r][c] = r_win[r][c];
                end
            end
        end
    end

    // Sobel gradients and squared magnitude per channel, red first
    always_comb begin
        logic [11:0]        px;
        logic [11:0]        nx;
        logic [11:0]        py;
        logic [11:0]        ny;
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        for (int ch = 0; ch < 3; ch++) begin
            px = 12'(m_win[0][2][(2-ch)*8 +: 8]) + {3'b0, m_win[1][2][(2-ch)*8 +: 8], 1'b0}
               + 12'(m_win[2][2][(2-ch)*8 +: 8]);
            nx = 12'(m_win[0][0][(2-ch)*8 +: 8]) + {3'b0, m_win[1][0][(2-ch)*8 +: 8], 1'b0}
               + 12'(m_win[2][0][(2-ch)*8 +: 8]);
            py = 12'(m_win[2][0][(2-ch)*8 +: 8]) + {3'b0, m_win[2][1][(2-ch)*8 +: 8], 1'b0}
               + 12'(m_win[2][2][(2-ch)*8 +: 8]);
            ny = 12'(m_win[0][0][(2-ch)*8 +: 8]) + {3'b0, m_win[0][1][(2-ch)*8 +: 8], 1'b0}
               + 12'(m_win[0][2][(2-ch)*8 +: 8]);
            gx = $signed(px - nx);
            gy = $signed(py - ny);
            sx = 24'(gx) * 24'(gx);
            sy = 24'(gy) * 24'(gy);
            sq_v[ch] = sem_pkg::SQ_W'(sx + sy);
        end
    end

    assign root_go = (r_state == S_GRAD);

    for (genvar g = 0; g < 3; g++) begin : g_root
        sem_root u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (root_go),
            .i_val   (sq_v[g]),
            .o_root  (root[g]),
            .o_sts   (root_sts[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !in_drop) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                n_state = has_out ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (root_sts[0].done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (cfg_wr) begin
            // drop anything in flight
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register: load when empty or when its beat leaves this cycle
    assign out_load = (r_state == S_LOAD) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_ch[ch] <= root[ch];
            end
            r_out_end <= r_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_blue  = r_out_ch[2];
    assign o_frame_end = r_out_end;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sem_pkg::DIM_W'(r_col) < w_eff || $past(cfg_wr))
        else $error("row store column beyond frame width");

    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_LOAD)
        else $error("result appeared without a root hand-off");

    a_roots_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_sts[0] == root_sts[1] && root_sts[1] == root_sts[2])
        else $error("channel roots out of step");

    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> root_sts[0].done)
        else $error("hand-off before the root finished");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
} t_edge_px;

class sobel_scoreboard;
    logic [47:0] line_mem [1024];
    logic [23:0] win [3][3];
    int unsigned pos;
    int unsigned reg_width;
    int unsigned reg_height;
    t_edge_px    pending [$];
    int unsigned errors;
    bit          frame_closed;

    function new();
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[r, c]) win[r][c] = '0;
        pos = 0;
        reg_width = 1024;
        reg_height = 1024;
        errors = 0;
        frame_closed = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
        if (idx == sem_pkg::REG_WIDTH) reg_width = val[10:0];
        else reg_height = val[10:0];
        pos = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function logic [7:0] round_root(int unsigned v);
        int unsigned k;
        int unsigned t;
        k = 0;
        if (v > 65280) return 8'd255;
        for (int b = 7; b >= 0; b--) begin
            t = k | (1 << b);
            if (t * t <= v) k = t;
        end
        if (v > k * k + k) k++;
        return k[7:0];
    endfunction

    function logic [7:0] magnitude(logic [23:0] m [3][3], int sh);
        int gx;
        int gy;
        int p [3][3];
        foreach (m[r, c]) p[r][c] = (m[r][c] >> sh) & 8'hFF;
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        return round_root(gx * gx + gy * gy);
    endfunction

    // advance the model by one accepted input beat
    function void note_beat(logic flush, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned p;
        int unsigned col;
        int unsigned q;
        int unsigned rc;
        int unsigned cc;
        logic [23:0] x;
        logic [47:0] e;
        logic [23:0] m [3][3];
        t_edge_px px;
        bit off;
        w = clamp_dim(reg_width, 1024);
        h = clamp_dim(reg_height, 1024);
        total = w * h;
        p = pos;
        if (p < total && flush) return;
        x = (p < total) ? {r, g, b} : 24'd0;
        col = p % w;
        e = line_mem[col];
        line_mem[col] = {e[23:0], x};
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = e[47:24];
        win[1][2] = e[23:0];
        win[2][2] = x;
        pos = p + 1;
        if (p < w + 1) return;
        q = p - w - 1;
        rc = q / w;
        cc = q % w;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                off = (i == 0 && rc == 0) || (i == 2 && rc + 1 >= h) ||
                      (j == 0 && cc == 0) || (j == 2 && cc + 1 >= w);
                m[i][j] = off ? 24'd0 : win[i][j];
            end
        end
        px.red = magnitude(m, 16);
        px.green = magnitude(m, 8);
        px.blue = magnitude(m, 0);
        px.frame_end = (q + 1 >= total);
        if (px.frame_end) begin
            pos = 0;
            frame_closed = 1;
        end
        pending.push_back(px);
    endfunction

    function void check_result(t_edge_px got);
        t_edge_px want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result r=%0d g=%0d b=%0d end=%0b",
                         got.red, got.green, got.blue, got.frame_end);
            return;
        end
        want = pending.pop_front();
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected r=%0d g=%0d b=%0d end=%0b, %s",
                         want.red, want.green, want.blue, want.frame_end,
                         $sformatf("got r=%0d g=%0d b=%0d end=%0b",
                                   got.red, got.green, got.blue, got.frame_end));
        end
    endfunction
endclass

module tb;
    localparam int LIMIT = 3000000;
    localparam int SETTLE = 30;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [7:0]  i_in_red = 0;
    logic [7:0]  i_in_green = 0;
    logic [7:0]  i_in_blue = 0;
    logic        i_flush = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_frame_end;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [sem_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sobel_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned beats_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    bit          hold_req = 0;

    sobel_edge_magnitude_rgb uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // global watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cycles = 400;
            hold_req = 0;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // check every result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_out_red, o_out_green, o_out_blue, o_frame_end});
    end

    // offer one beat and hold it until the block takes it
    task automatic send_beat(logic flush, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_flush <= flush;
        i_in_red <= r;
        i_in_green <= g;
        i_in_blue <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(flush, r, g, b);
        beats_sent++;
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drop valid and wait until every expected result is out and the block settles
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // run one frame; stop early after cut_at pixels when cut_at is nonzero
    task automatic run_frame(logic [31:0] w, logic [31:0] h, int unsigned cut_at);
        int unsigned pix;
        drain_block();
        apb_write(sem_pkg::REG_WIDTH, w);
        apb_write(sem_pkg::REG_HEIGHT, h);
        sb.frame_closed = 0;
        pix = 0;
        while (!sb.frame_closed) begin
            if (cut_at != 0 && pix >= cut_at) break;
            // stray flushes inside the frame and stray pixels during drain
            if ($urandom_range(99) < 6)
                send_beat(1'b1, pick_chan(), pick_chan(), pick_chan());
            else if (sb.pos < sb.clamp_dim(sb.reg_width, 1024) *
                              sb.clamp_dim(sb.reg_height, 1024)) begin
                send_beat(1'b0, pick_chan(), pick_chan(), pick_chan());
                pix++;
            end else
                send_beat($urandom_range(99) < 80, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tiny frames, zero-valued registers, bright checker pattern
        apb_write(sem_pkg::REG_WIDTH, 3);
        apb_write(sem_pkg::REG_HEIGHT, 3);
        sb.frame_closed = 0;
        for (int i = 0; i < 9; i++)
            send_beat(1'b0, (i % 2) ? 8'd255 : 8'd0, 8'd255, (i % 3) ? 8'd0 : 8'd255);
        send_beat(1'b0, 8'hAA, 8'h55, 8'hFF);
        while (!sb.frame_closed) send_beat(1'b1, 8'd0, 8'd0, 8'd0);
        run_frame(0, 0, 0);
        run_frame(2, 2, 0);
        run_frame(4, 3, 5);

        // random frames over three idling regimes
        hold_req = 1;
        while (beats_sent < 2000) begin
            if (beats_sent < 700) begin
                send_idle_pct = 15;
                recv_idle_pct = 48;
            end else if (beats_sent < 1400) begin
                send_idle_pct = 48;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            case ($urandom_range(19))
                0: w = 0;
                1: h = 0;
                2: h = 2047;
                default: ;
            endcase
            if (h == 2047) w = 1;
            if ($urandom_range(29) == 0) hold_req = 1;
            run_frame(w, h, ($urandom_range(9) == 0) ? $urandom_range(1, w * h + 1) : 0);
        end

        drain_block();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sobel_edge_magnitude_rgb.f]
src/sem_pkg.sv
src/sem_ram.sv
src/sem_root.sv
src/sobel_edge_magnitude_rgb.sv
tb/tb.sv
